### src/u8d_pkg.sv
// Package with item types, decoder state type and constants for the UTF-8 decoder.
package u8d_pkg;

	localparam int unsigned CpWidth = 21;

	localparam logic [CpWidth-1:0] Replacement = 21'h00FFFD;
	localparam logic [CpWidth-1:0] SurrogateLo = 21'h00D800;
	localparam logic [CpWidth-1:0] SurrogateHi = 21'h00DFFF;

	localparam logic [2:0] LenNone = 3'd0;
	localparam logic [2:0] LenTwo = 3'd2;
	localparam logic [2:0] LenThree = 3'd3;
	localparam logic [2:0] LenFour = 3'd4;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		logic [CpWidth-1:0] code_point;
		logic               decode_error;
		logic               last_of_run;
	} out_item_t;

	typedef struct packed {
		logic [2:0]         seq_len;
		logic [1:0]         bytes_rcvd;
		logic [CpWidth-1:0] partial;
		logic               skip;
	} dec_state_t;

	typedef struct packed {
		logic [1:0]      count;
		out_item_t [1:0] res;
	} dec_out_t;

endpackage

### src/u8d_decode.sv
// Combinational decode of one byte against the current decoder state.
module u8d_decode (
	input  u8d_pkg::dec_state_t state,
	input  u8d_pkg::in_item_t   item,
	output u8d_pkg::dec_state_t state_nxt,
	output u8d_pkg::dec_out_t   result
);

	logic [7:0]                   b;
	logic                         eot;
	logic                         cont;
	logic                         handled;
	logic                         done;
	logic [1:0]                   br_inc;
	logic [u8d_pkg::CpWidth-1:0]  pv_ext;
	logic [u8d_pkg::CpWidth-1:0]  cp_done;
	logic [2:0]                   lead_len;
	logic [u8d_pkg::CpWidth-1:0]  lead_init;

	always_comb begin
		b = item.text_byte;
		eot = item.end_of_text;
		cont = (b[7:6] == 2'b10);
		pv_ext = {state.partial[u8d_pkg::CpWidth-7:0], b[5:0]};
		br_inc = state.bytes_rcvd + 2'd1;
		done = (({1'b0, br_inc} + 3'd1) >= state.seq_len);
		cp_done = pv_ext;
		if (state.seq_len == u8d_pkg::LenThree && pv_ext >= u8d_pkg::SurrogateLo
				&& pv_ext <= u8d_pkg::SurrogateHi) begin
			cp_done = u8d_pkg::Replacement;
		end
	end

	always_comb begin
		lead_len = u8d_pkg::LenNone;
		lead_init = '0;
		if (b[7:5] == 3'b110 && b[4:0] != 5'd0) begin
			lead_len = u8d_pkg::LenTwo;
			lead_init = {16'd0, b[4:0]};
		end else if (b[7:4] == 4'b1110 && b[3:0] != 4'd0) begin
			lead_len = u8d_pkg::LenThree;
			lead_init = {17'd0, b[3:0]};
		end else if (b[7:3] == 5'b11110 && b[2:0] != 3'd0) begin
			lead_len = u8d_pkg::LenFour;
			lead_init = {18'd0, b[2:0]};
		end
	end

	always_comb begin
		state_nxt = state;
		result = '0;
		handled = 1'b0;

		if (state.seq_len != u8d_pkg::LenNone) begin
			if (cont) begin
				state_nxt.partial = pv_ext;
				state_nxt.bytes_rcvd = br_inc;
				if (done) begin
					result.res[result.count[0]].code_point = cp_done;
					result.res[result.count[0]].decode_error = 1'b0;
					result.count = result.count + 2'd1;
					state_nxt.seq_len = u8d_pkg::LenNone;
					state_nxt.bytes_rcvd = '0;
					state_nxt.partial = '0;
				end else if (eot) begin
					result.res[result.count[0]].code_point = u8d_pkg::Replacement;
					result.res[result.count[0]].decode_error = 1'b1;
					result.count = result.count + 2'd1;
					state_nxt.seq_len = u8d_pkg::LenNone;
					state_nxt.bytes_rcvd = '0;
					state_nxt.partial = '0;
				end
				handled = 1'b1;
			end else begin
				result.res[result.count[0]].code_point = u8d_pkg::Replacement;
				result.res[result.count[0]].decode_error = 1'b1;
				result.count = result.count + 2'd1;
				state_nxt.seq_len = u8d_pkg::LenNone;
				state_nxt.bytes_rcvd = '0;
				state_nxt.partial = '0;
				state_nxt.skip = 1'b1;
			end
		end

		if (!handled) begin
			if (state_nxt.skip) begin
				if (!b[7]) begin
					state_nxt.skip = 1'b0;
					result.res[result.count[0]].code_point = {13'd0, b};
					result.res[result.count[0]].decode_error = 1'b0;
					result.count = result.count + 2'd1;
				end
			end else if (!b[7]) begin
				result.res[result.count[0]].code_point = {13'd0, b};
				result.res[result.count[0]].decode_error = 1'b0;
				result.count = result.count + 2'd1;
			end else if (lead_len == u8d_pkg::LenNone) begin
				result.res[result.count[0]].code_point = u8d_pkg::Replacement;
				result.res[result.count[0]].decode_error = 1'b1;
				result.count = result.count + 2'd1;
				state_nxt.skip = 1'b1;
			end else if (eot) begin
				result.res[result.count[0]].code_point = u8d_pkg::Replacement;
				result.res[result.count[0]].decode_error = 1'b1;
				result.count = result.count + 2'd1;
			end else begin
				state_nxt.seq_len = lead_len;
				state_nxt.bytes_rcvd = '0;
				state_nxt.partial = lead_init;
			end
		end

		if (eot) begin
			state_nxt = '0;
		end
		if (result.count != 2'd0) begin
			result.res[result.count[1]].last_of_run = 1'b1;
		end
	end

endmodule

### src/u8d_result_buf.sv
// Two-entry result buffer that takes up to two results per item and hands out one per cycle while point_stall is low.
module u8d_result_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	input  u8d_pkg::dec_out_t   push,
	output logic                push_ready,
	output logic                point_valid,
	input  logic                point_stall,
	output u8d_pkg::out_item_t  point_item
);

	u8d_pkg::out_item_t [1:0] ent_q;
	u8d_pkg::out_item_t [1:0] ent_nxt;
	u8d_pkg::out_item_t       head_shift;
	logic [1:0]               count_q;
	logic [1:0]               cnt_after;
	logic [2:0]               cnt_sum;
	logic                     pop;
	logic                     take;

	assign point_valid = (count_q != 2'd0);
	assign point_item = ent_q[0];
	assign pop = point_valid && !point_stall;
	assign cnt_after = count_q - {1'b0, pop};
	assign cnt_sum = {1'b0, cnt_after} + {1'b0, push.count};
	assign push_ready = (cnt_sum <= 3'd2);
	assign take = push_valid && push_ready;
	assign head_shift = pop ? ent_q[1] : ent_q[0];

	always_comb begin
		ent_nxt = ent_q;
		case (cnt_after)
			2'd0: begin
				ent_nxt[0] = push.res[0];
				ent_nxt[1] = push.res[1];
			end
			2'd1: begin
				ent_nxt[0] = head_shift;
				ent_nxt[1] = push.res[0];
			end
			default: begin
				ent_nxt = ent_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= take ? cnt_sum[1:0] : cnt_after;
		end
	end

	always_ff @(posedge clk) begin
		ent_q <= ent_nxt;
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q != 2'd3)
		else $error("result buffer count out of range");

endmodule

### src/utf8_to_codepoint_decoder_core.sv
// Top level of the UTF-8 decoder: input register, state registers, decode and result buffer.
// An item's first result is offered once it has passed the input register and the result buffer.
// Throughput: one byte per cycle while byte_stall is low; a byte that yields two results fills
// both result buffer entries. Bytes that yield no result still pass through the input register.
// Reset (arst_n low) empties the input register and result buffer and clears decoder state.
module utf8_to_codepoint_decoder_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_stall,
	input  u8d_pkg::in_item_t  byte_item,
	output logic               point_valid,
	input  logic               point_stall,
	output u8d_pkg::out_item_t point_item
);

	logic                valid_s1;
	u8d_pkg::in_item_t   item_s1;
	u8d_pkg::dec_state_t state_q;
	u8d_pkg::dec_state_t state_nxt;
	u8d_pkg::dec_out_t   dec_res;
	logic                buf_ready;
	logic                adv;
	logic                accept;

	assign adv = valid_s1 && buf_ready;
	assign byte_stall = valid_s1 && !buf_ready;
	assign accept = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= byte_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	u8d_decode u_decode (
		.state     (state_q),
		.item      (item_s1),
		.state_nxt (state_nxt),
		.result    (dec_res)
	);

	u8d_result_buf u_result_buf (
		.clk         (clk),
		.arst_n      (arst_n),
		.push_valid  (valid_s1),
		.push        (dec_res),
		.push_ready  (buf_ready),
		.point_valid (point_valid),
		.point_stall (point_stall),
		.point_item  (point_item)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q.seq_len == u8d_pkg::LenNone || state_q.seq_len == u8d_pkg::LenTwo
		|| state_q.seq_len == u8d_pkg::LenThree || state_q.seq_len == u8d_pkg::LenFour)
		else $error("illegal pending sequence length");

	assert property (@(posedge clk) disable iff (!arst_n)
		!(state_q.seq_len != u8d_pkg::LenNone && state_q.skip))
		else $error("skip mode while a sequence is pending");

	assert property (@(posedge clk) disable iff (!arst_n)
		adv && item_s1.end_of_text |=> state_q == '0)
		else $error("state not cleared after end of text");

	assert property (@(posedge clk) disable iff (!arst_n)
		adv && dec_res.count == 2'd0 |=> $stable(point_valid) || $past(point_valid && !point_stall))
		else $error("item without result changed output");

endmodule
